// ===== hdl/yuyv_to_bgra_framebuffer_writer_top_assert.svh =====
// assertion macros for the yuyv to bgra framebuffer writer
`ifndef YUYV_TO_BGRA_FRAMEBUFFER_WRITER_TOP_ASSERT_SVH
`define YUYV_TO_BGRA_FRAMEBUFFER_WRITER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define YBFW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ybfw same-cycle check failed");

// next-cycle implication, checked out of reset
`define YBFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ybfw next-cycle check failed");

`endif

// ===== hdl/ybfw_pkg.sv =====
// shared types, constants and color conversion for the framebuffer writer
package ybfw_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int CFG_COORD_W        = 12;
    localparam int CFG_BPP_W          = 3;
    localparam int CFG_LINE_W         = 14;
    localparam int CFG_DATA_W         = 14;
    localparam int CFG_INDEX_W        = 3;
    localparam int ADDR_W             = 28;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_ORIGIN_X        = 3'd2,
        REG_ORIGIN_Y        = 3'd3,
        REG_PAN_X           = 3'd4,
        REG_PAN_Y           = 3'd5,
        REG_BYTES_PER_PIXEL = 3'd6,
        REG_LINE_BYTES      = 3'd7
    } cfg_reg_t;

    localparam logic [CFG_COORD_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_COORD_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [CFG_COORD_W-1:0] RST_ORIGIN_X     = 12'd100;
    localparam logic [CFG_COORD_W-1:0] RST_ORIGIN_Y     = 12'd100;
    localparam logic [CFG_COORD_W-1:0] RST_PAN_X        = 12'd0;
    localparam logic [CFG_COORD_W-1:0] RST_PAN_Y        = 12'd0;
    localparam logic [CFG_BPP_W-1:0]   RST_BPP          = 3'd4;
    localparam logic [CFG_LINE_W-1:0]  RST_LINE_BYTES   = 14'd4096;

    // bt.601 integer coefficients
    localparam logic signed [19:0] C_Y   = 20'sd298;
    localparam logic signed [19:0] C_RV  = 20'sd409;
    localparam logic signed [19:0] C_GU  = 20'sd100;
    localparam logic signed [19:0] C_GV  = 20'sd208;
    localparam logic signed [19:0] C_BU  = 20'sd516;
    localparam logic signed [19:0] C_RND = 20'sd128;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } yuyv_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] fb_address;
        logic [7:0]        blue_first;
        logic [7:0]        green_first;
        logic [7:0]        red_first;
        logic [7:0]        blue_second;
        logic [7:0]        green_second;
        logic [7:0]        red_second;
        logic              frame_end;
    } bgra_out_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } bgr_t;

    // floor shift by 8, then clamp to 0..255
    function automatic logic [7:0] shift_clamp(input logic signed [19:0] acc);
        logic signed [11:0] s;
        s = 12'(acc >>> 8);
        if (s < 12'sd0)
            return 8'd0;
        else if (s > 12'sd255)
            return 8'd255;
        else
            return s[7:0];
    endfunction

    function automatic bgr_t convert_pixel(input logic [7:0] y, input logic [7:0] cb,
                                           input logic [7:0] cr);
        logic signed [7:0]  u8;
        logic signed [7:0]  v8;
        logic signed [19:0] yy;
        logic signed [19:0] uu;
        logic signed [19:0] vv;
        bgr_t               p;
        // subtracting 128 from a byte flips its top bit
        u8 = signed'({~cb[7], cb[6:0]});
        v8 = signed'({~cr[7], cr[6:0]});
        yy = signed'({12'd0, y});
        uu = 20'(u8);
        vv = 20'(v8);
        p.blue  = shift_clamp(yy * C_Y + uu * C_BU + C_RND);
        p.green = shift_clamp(yy * C_Y - uu * C_GU - vv * C_GV + C_RND);
        p.red   = shift_clamp(yy * C_Y + vv * C_RV + C_RND);
        return p;
    endfunction

endpackage

// ===== hdl/yuyv_to_bgra_framebuffer_writer_top.sv =====
// an accepted request passes through the stage 1 registers and result_reg to out_data
// throughput: one macropixel per cycle unless stalled; two-register pipeline with no loop
// the position counters update on input accept; address multiply and color math run in stage 2
// reset clears valids and counters and loads the configuration defaults
// output stalls back up through stage 1 to in_ready
module yuyv_to_bgra_framebuffer_writer_top
    import ybfw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  yuyv_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bgra_out_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WIDE_W = (COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W;
    localparam int CMP_W  = WIDE_W + 1;
    localparam int SCR_W  = WIDE_W + 2;
    localparam int PX_W   = SCR_W + CFG_BPP_W;
    localparam int PY_W   = SCR_W + CFG_LINE_W;

    // configuration
    logic [CFG_COORD_W-1:0] frame_width_reg;
    logic [CFG_COORD_W-1:0] frame_height_reg;
    logic [CFG_COORD_W-1:0] origin_x_reg;
    logic [CFG_COORD_W-1:0] origin_y_reg;
    logic [CFG_COORD_W-1:0] pan_x_reg;
    logic [CFG_COORD_W-1:0] pan_y_reg;
    logic [CFG_BPP_W-1:0]   bpp_reg;
    logic [CFG_LINE_W-1:0]  line_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            origin_x_reg     <= RST_ORIGIN_X;
            origin_y_reg     <= RST_ORIGIN_Y;
            pan_x_reg        <= RST_PAN_X;
            pan_y_reg        <= RST_PAN_Y;
            bpp_reg          <= RST_BPP;
            line_bytes_reg   <= RST_LINE_BYTES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:     frame_width_reg  <= cfg_data[CFG_COORD_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg <= cfg_data[CFG_COORD_W-1:0];
                REG_ORIGIN_X:        origin_x_reg     <= cfg_data[CFG_COORD_W-1:0];
                REG_ORIGIN_Y:        origin_y_reg     <= cfg_data[CFG_COORD_W-1:0];
                REG_PAN_X:           pan_x_reg        <= cfg_data[CFG_COORD_W-1:0];
                REG_PAN_Y:           pan_y_reg        <= cfg_data[CFG_COORD_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg          <= cfg_data[CFG_BPP_W-1:0];
                REG_LINE_BYTES:      line_bytes_reg   <= cfg_data[CFG_LINE_W-1:0];
                default:             ;
            endcase
        end
    end

    // handshake and pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_advance;
    logic in_accept;

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // position counters
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] col_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    logic                  row_end;
    logic                  frame_end_now;

    assign row_end = (CMP_W'(col_reg) + CMP_W'(2)) >= CMP_W'(frame_width_reg);
    assign frame_end_now = row_end &&
                           ((CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(frame_height_reg));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (frame_end_now)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = row_reg + COORD_BITS'(1);
        end
        else
        begin
            col_next = col_reg + COORD_BITS'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: captured pixel data and screen coordinates
    yuyv_in_t         s1_data_reg;
    logic [SCR_W-1:0] s1_xs_reg;
    logic [SCR_W-1:0] s1_ys_reg;
    logic             s1_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg      <= in_data;
            s1_xs_reg        <= SCR_W'(origin_x_reg) + SCR_W'(pan_x_reg) + SCR_W'(col_reg);
            s1_ys_reg        <= SCR_W'(origin_y_reg) + SCR_W'(pan_y_reg) + SCR_W'(row_reg);
            s1_frame_end_reg <= frame_end_now;
        end
    end

    // stage 2: address and color conversion
    logic [PX_W-1:0] addr_x;
    logic [PY_W-1:0] addr_y;
    bgr_t            pix_first;
    bgr_t            pix_second;
    bgra_out_t       result_next;
    bgra_out_t       result_reg;

    assign addr_x     = PX_W'(s1_xs_reg) * PX_W'(bpp_reg);
    assign addr_y     = PY_W'(s1_ys_reg) * PY_W'(line_bytes_reg);
    assign pix_first  = convert_pixel(s1_data_reg.luma_first, s1_data_reg.chroma_blue,
                                      s1_data_reg.chroma_red);
    assign pix_second = convert_pixel(s1_data_reg.luma_second, s1_data_reg.chroma_blue,
                                      s1_data_reg.chroma_red);

    always_comb
    begin
        result_next.fb_address   = ADDR_W'(addr_x) + ADDR_W'(addr_y);
        result_next.blue_first   = pix_first.blue;
        result_next.green_first  = pix_first.green;
        result_next.red_first    = pix_first.red;
        result_next.blue_second  = pix_second.blue;
        result_next.green_second = pix_second.green;
        result_next.red_second   = pix_second.red;
        result_next.frame_end    = s1_frame_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    // checks
`include "yuyv_to_bgra_framebuffer_writer_top_assert.svh"

    `YBFW_ASSERT_NOW(a_col_even, 1'b1, !col_reg[0])
    `YBFW_ASSERT_NEXT(a_frame_wrap, in_accept && frame_end_now, col_reg == '0 && row_reg == '0)
    `YBFW_ASSERT_NOW(a_stall_cause, s1_valid_reg && !in_ready, out_valid_reg && !out_ready)

endmodule
